>>> src/pic_pkg.sv
// Shared types, widths and constants for the predictive incremental controller.
package pic_pkg;

  localparam int DATA_W      = 31;
  localparam int DELTA_W     = 32;
  localparam int ALPHA_W     = 20;
  localparam int STEPS_W     = 8;
  localparam int WIN_W       = STEPS_W + 1;
  localparam int ASUM_W      = 17;
  localparam int BSUM_W      = 26;
  localparam int DEN_W       = 17;
  localparam int DEN2_W      = 26;
  localparam int MAG_W       = 32;
  localparam int GAIN_W      = 28;
  localparam int MUL_A_W     = 32;
  localparam int MUL_B_W     = 28;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int DIV_NW      = 55;
  localparam int DIV_CW      = 6;
  localparam int T1_W        = 34;
  localparam int T2_W        = 37;
  localparam int DSUM_W      = 38;
  localparam int CSUM_W      = DATA_W + 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;

  localparam int FRAC_BITS   = 16;
  localparam int GAIN_EXTRA  = 8;
  localparam int TERM2_SHIFT = FRAC_BITS + GAIN_EXTRA;
  localparam int MIN_WINDOW  = 64;
  localparam int OUT_LIMIT   = 655360000;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX   = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_LOAD  = 4'd1,
    OP_SETUP = 4'd2,
    OP_MAC   = 4'd3,
    OP_DEN   = 4'd4,
    OP_NUM1  = 4'd5,
    OP_TERM1 = 4'd6,
    OP_NUM2  = 4'd7,
    OP_TERM2 = 4'd8,
    OP_DELTA = 4'd9,
    OP_SUM   = 4'd10
  } op_t;

  typedef struct packed {
    logic in_fire;
    logic mac_last;
    logic div_busy;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic        [ALPHA_W-1:0] alpha;
    logic        [STEPS_W-1:0] steps;
    logic signed [DATA_W-1:0]  min_out;
    logic signed [DATA_W-1:0]  max_out;
  } cfg_t;

endpackage

>>> src/pic_if.sv
// Valid/ready channel interfaces for the input and result words.
interface pic_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pic_pkg::DATA_W-1:0] target;
  logic signed [pic_pkg::DATA_W-1:0] measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink (input valid, input target, input measured, output ready);
endinterface

interface pic_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pic_pkg::DATA_W-1:0]  control;
  logic signed [pic_pkg::DELTA_W-1:0] step_delta;
  logic                                baseline_captured;

  modport source (output valid, output control, output step_delta,
                  output baseline_captured, input ready);
  modport sink (input valid, input control, input step_delta,
                input baseline_captured, output ready);
endinterface

>>> src/pic_div.sv
// Restoring divider, one quotient bit per cycle.
module pic_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pic_pkg::DIV_NW-1:0] num,
  input  logic [pic_pkg::DEN2_W-1:0] den,
  output logic                        busy,
  output logic [pic_pkg::DIV_NW-1:0] quot
);

  logic [pic_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [pic_pkg::DEN2_W-1:0] rem_r, rem_nxt;
  logic [pic_pkg::DEN2_W-1:0] den_r, den_nxt;
  logic [pic_pkg::DIV_NW-1:0] q_r, q_nxt;
  logic [pic_pkg::DEN2_W:0]   trial;
  logic [pic_pkg::DEN2_W:0]   diff;
  logic                       ge;

  assign trial = {rem_r, q_r[pic_pkg::DIV_NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign busy  = cnt_r != '0;
  assign quot  = q_r;

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt   = q_r;
    if (start) begin
      cnt_nxt = pic_pkg::DIV_CW'(pic_pkg::DIV_NW);
      rem_nxt = '0;
      den_nxt = den;
      q_nxt   = num;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = ge ? diff[pic_pkg::DEN2_W-1:0] : trial[pic_pkg::DEN2_W-1:0];
      q_nxt   = {q_r[pic_pkg::DIV_NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

endmodule

>>> src/pic_useq.sv
// Microcode sequencer: step counter, control store and jump conditions.
module pic_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  pic_pkg::stat_t stat,
  output pic_pkg::op_t   op
);

  typedef logic [3:0] step_t;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_JUMP     = 3'd1,
    C_NO_IN    = 3'd2,
    C_MAC      = 3'd3,
    C_DIV      = 3'd4,
    C_OUT_BUSY = 3'd5
  } cond_t;

  typedef struct packed {
    pic_pkg::op_t op;
    cond_t        cond;
    step_t        tgt;
  } uword_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_SETUP = 4'd1;
  localparam step_t S_MAC   = 4'd2;
  localparam step_t S_DEN   = 4'd3;
  localparam step_t S_NUM1  = 4'd4;
  localparam step_t S_DIV1  = 4'd5;
  localparam step_t S_TERM1 = 4'd6;
  localparam step_t S_NUM2  = 4'd7;
  localparam step_t S_DIV2  = 4'd8;
  localparam step_t S_TERM2 = 4'd9;
  localparam step_t S_DELTA = 4'd10;
  localparam step_t S_SUM   = 4'd11;
  localparam step_t S_RET   = 4'd12;

  function automatic uword_t rom(input step_t a);
    uword_t w;
    unique case (a)
      S_IDLE:  w = '{pic_pkg::OP_LOAD,  C_NO_IN,    S_IDLE};
      S_SETUP: w = '{pic_pkg::OP_SETUP, C_NEXT,     S_IDLE};
      S_MAC:   w = '{pic_pkg::OP_MAC,   C_MAC,      S_MAC};
      S_DEN:   w = '{pic_pkg::OP_DEN,   C_NEXT,     S_IDLE};
      S_NUM1:  w = '{pic_pkg::OP_NUM1,  C_NEXT,     S_IDLE};
      S_DIV1:  w = '{pic_pkg::OP_NOP,   C_DIV,      S_DIV1};
      S_TERM1: w = '{pic_pkg::OP_TERM1, C_NEXT,     S_IDLE};
      S_NUM2:  w = '{pic_pkg::OP_NUM2,  C_NEXT,     S_IDLE};
      S_DIV2:  w = '{pic_pkg::OP_NOP,   C_DIV,      S_DIV2};
      S_TERM2: w = '{pic_pkg::OP_TERM2, C_NEXT,     S_IDLE};
      S_DELTA: w = '{pic_pkg::OP_DELTA, C_NEXT,     S_IDLE};
      S_SUM:   w = '{pic_pkg::OP_SUM,   C_OUT_BUSY, S_SUM};
      S_RET:   w = '{pic_pkg::OP_NOP,   C_JUMP,     S_IDLE};
      default: w = '{pic_pkg::OP_NOP,   C_JUMP,     S_IDLE};
    endcase
    return w;
  endfunction

  step_t  step_r, step_nxt;
  uword_t uw;
  logic   jump;

  assign uw = rom(step_r);
  assign op = uw.op;

  always_comb begin
    unique case (uw.cond)
      C_NEXT:     jump = 1'b0;
      C_JUMP:     jump = 1'b1;
      C_NO_IN:    jump = !stat.in_fire;
      C_MAC:      jump = !stat.mac_last;
      C_DIV:      jump = stat.div_busy;
      C_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b1;
    endcase
    step_nxt = jump ? uw.tgt : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> src/pic_dpath.sv
// Datapath: operand registers, shared multiplier, divider and output register.
module pic_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  pic_pkg::op_t   op,
  input  pic_pkg::cfg_t  cfg,
  output pic_pkg::stat_t stat,
  pic_in_if.sink         in_ch,
  pic_out_if.source      out_ch
);

  logic signed [pic_pkg::DATA_W-1:0]  tgt_r, meas_r, base_r;
  logic                               bvalid_r, cap_r;
  logic        [pic_pkg::WIN_W-1:0]   win_r;
  logic signed [pic_pkg::DATA_W-1:0]  ctrl_r;
  logic        [pic_pkg::STEPS_W-1:0] s_r, i_r;
  logic        [pic_pkg::WIN_W-1:0]   n_r;
  logic        [pic_pkg::ASUM_W-1:0]  a_r;
  logic        [pic_pkg::BSUM_W-1:0]  b_r;
  logic        [pic_pkg::DEN_W-1:0]   den_r;
  logic        [pic_pkg::DEN2_W-1:0]  den2_r;
  logic        [pic_pkg::MAG_W-1:0]   dmag_r, emag_r;
  logic                               dneg_r, eneg_r;
  logic signed [pic_pkg::T1_W-1:0]    term1_r;
  logic signed [pic_pkg::T2_W-1:0]    term2_r;
  logic signed [pic_pkg::DELTA_W-1:0] delta_r;
  logic                               out_valid_r;
  logic signed [pic_pkg::DATA_W-1:0]  out_ctrl_r;
  logic signed [pic_pkg::DELTA_W-1:0] out_delta_r;
  logic                               out_cap_r;

  logic                               in_fire, out_busy;
  logic        [pic_pkg::STEPS_W-1:0] s_eff;
  logic        [pic_pkg::WIN_W-1:0]   n_raw, n_eff;
  logic                               capture;
  logic signed [pic_pkg::MAG_W-1:0]   e_full, d_full;
  logic        [pic_pkg::WIN_W-1:0]   w_term, v_term;
  logic        [pic_pkg::MUL_A_W-1:0] mul_a;
  logic        [pic_pkg::MUL_B_W-1:0] mul_b;
  logic        [pic_pkg::PROD_W-1:0]  prod, prod_rnd;
  logic                               div_start, div_busy;
  logic        [pic_pkg::DIV_NW-1:0]  div_num, quot;
  logic        [pic_pkg::DEN2_W-1:0]  div_den;
  logic        [pic_pkg::T1_W-2:0]    q1;
  logic        [pic_pkg::PROD_W-pic_pkg::TERM2_SHIFT-1:0] q2;
  logic signed [pic_pkg::DSUM_W-1:0]  dsum;
  logic        [pic_pkg::DSUM_W-pic_pkg::DELTA_W:0]       dtop;
  logic signed [pic_pkg::DELTA_W-1:0] delta_sat;
  logic signed [pic_pkg::CSUM_W-1:0]  csum, clo, chi, c_lo, c_fin;

  assign in_ch.ready = op == pic_pkg::OP_LOAD;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_busy    = out_valid_r && !out_ch.ready;

  assign stat.in_fire  = in_fire;
  assign stat.mac_last = i_r == s_r - 1'b1;
  assign stat.div_busy = div_busy;
  assign stat.out_busy = out_busy;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.control           = out_ctrl_r;
  assign out_ch.step_delta        = out_delta_r;
  assign out_ch.baseline_captured = out_cap_r;

  assign s_eff   = (cfg.steps == '0) ? pic_pkg::STEPS_W'(1) : cfg.steps;
  assign n_raw   = {1'b0, s_eff} + pic_pkg::WIN_W'(2);
  assign n_eff   = (n_raw < pic_pkg::WIN_W'(pic_pkg::MIN_WINDOW)) ?
                   pic_pkg::WIN_W'(pic_pkg::MIN_WINDOW) : n_raw;
  assign capture = !bvalid_r || (win_r != n_eff);
  assign e_full  = capture ? '0 :
                   pic_pkg::MAG_W'(meas_r) - pic_pkg::MAG_W'(base_r);
  assign d_full  = pic_pkg::MAG_W'(tgt_r) - pic_pkg::MAG_W'(meas_r);

  assign w_term = {s_r, 1'b0} - {1'b0, i_r};
  assign v_term = n_r - pic_pkg::WIN_W'(1) - {1'b0, i_r};

  always_comb begin
    case (op)
      pic_pkg::OP_MAC: begin
        mul_a = pic_pkg::MUL_A_W'(w_term);
        mul_b = pic_pkg::MUL_B_W'(v_term);
      end
      pic_pkg::OP_DEN: begin
        mul_a = pic_pkg::MUL_A_W'(s_r);
        mul_b = pic_pkg::MUL_B_W'(s_r);
      end
      pic_pkg::OP_NUM1: begin
        mul_a = dmag_r;
        mul_b = pic_pkg::MUL_B_W'(a_r);
      end
      pic_pkg::OP_TERM1: begin
        mul_a = pic_pkg::MUL_A_W'(den_r);
        mul_b = pic_pkg::MUL_B_W'(n_r);
      end
      pic_pkg::OP_NUM2: begin
        mul_a = pic_pkg::MUL_A_W'(b_r);
        mul_b = pic_pkg::MUL_B_W'(cfg.alpha);
      end
      pic_pkg::OP_TERM2: begin
        mul_a = emag_r;
        mul_b = quot[pic_pkg::GAIN_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_rnd = prod + (pic_pkg::PROD_W'(1) << (pic_pkg::TERM2_SHIFT - 1));
  assign q2       = prod_rnd[pic_pkg::PROD_W-1:pic_pkg::TERM2_SHIFT];
  assign q1       = quot[pic_pkg::T1_W-2:0];

  assign div_start = (op == pic_pkg::OP_NUM1) || (op == pic_pkg::OP_NUM2);
  assign div_num   = (op == pic_pkg::OP_NUM1) ?
                     pic_pkg::DIV_NW'(prod) + pic_pkg::DIV_NW'(den_r >> 1) :
                     pic_pkg::DIV_NW'({prod, {pic_pkg::GAIN_EXTRA{1'b0}}}) +
                     pic_pkg::DIV_NW'(den2_r >> 1);
  assign div_den   = (op == pic_pkg::OP_NUM1) ? pic_pkg::DEN2_W'(den_r) : den2_r;

  pic_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign dsum      = pic_pkg::DSUM_W'(term1_r) - pic_pkg::DSUM_W'(term2_r);
  assign dtop      = dsum[pic_pkg::DSUM_W-1:pic_pkg::DELTA_W-1];
  assign delta_sat = ((&dtop) || !(|dtop)) ? dsum[pic_pkg::DELTA_W-1:0] :
                     dsum[pic_pkg::DSUM_W-1] ? {1'b1, {(pic_pkg::DELTA_W-1){1'b0}}} :
                                               {1'b0, {(pic_pkg::DELTA_W-1){1'b1}}};

  assign csum  = pic_pkg::CSUM_W'(ctrl_r) + pic_pkg::CSUM_W'(delta_r);
  assign clo   = pic_pkg::CSUM_W'(cfg.min_out);
  assign chi   = pic_pkg::CSUM_W'(cfg.max_out);
  assign c_lo  = (csum < clo) ? clo : csum;
  assign c_fin = (c_lo > chi) ? chi : c_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r    <= 1'b0;
      win_r       <= '0;
      base_r      <= '0;
      ctrl_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == pic_pkg::OP_SETUP && capture) begin
        bvalid_r <= 1'b1;
        win_r    <= n_eff;
        base_r   <= meas_r;
      end
      if (op == pic_pkg::OP_SUM && !out_busy) begin
        ctrl_r      <= c_fin[pic_pkg::DATA_W-1:0];
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_fire) begin
      tgt_r  <= in_ch.target;
      meas_r <= in_ch.measured;
    end

    case (op)
      pic_pkg::OP_SETUP: begin
        s_r    <= s_eff;
        n_r    <= n_eff;
        i_r    <= '0;
        a_r    <= '0;
        b_r    <= '0;
        cap_r  <= capture;
        dneg_r <= d_full[pic_pkg::MAG_W-1];
        dmag_r <= d_full[pic_pkg::MAG_W-1] ? -d_full : d_full;
        eneg_r <= e_full[pic_pkg::MAG_W-1];
        emag_r <= e_full[pic_pkg::MAG_W-1] ? -e_full : e_full;
      end
      pic_pkg::OP_MAC: begin
        a_r <= a_r + pic_pkg::ASUM_W'(w_term);
        b_r <= b_r + pic_pkg::BSUM_W'(prod);
        i_r <= i_r + 1'b1;
      end
      pic_pkg::OP_DEN: begin
        den_r <= pic_pkg::DEN_W'({prod, 1'b0});
      end
      pic_pkg::OP_TERM1: begin
        term1_r <= dneg_r ? -pic_pkg::T1_W'(q1) : pic_pkg::T1_W'(q1);
        den2_r  <= pic_pkg::DEN2_W'(prod);
      end
      pic_pkg::OP_TERM2: begin
        term2_r <= eneg_r ? -pic_pkg::T2_W'(q2) : pic_pkg::T2_W'(q2);
      end
      pic_pkg::OP_DELTA: begin
        delta_r <= delta_sat;
      end
      pic_pkg::OP_SUM: begin
        if (!out_busy) begin
          out_ctrl_r  <= c_fin[pic_pkg::DATA_W-1:0];
          out_delta_r <= delta_r;
          out_cap_r   <= cap_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/predictive_incremental_controller.sv
// Top level of the predictive incremental controller: config registers, sequencer, datapath.
// One input word at a time, S = effective control_steps (1..255): the next word is not accepted
// until the result of the last is registered; the work per word is the one-term-per-cycle horizon
// MAC loop over S terms and two passes through the shared restoring divider.
// Reset (rst_n low, synchronous): sequencer to idle, config to defaults, baseline invalid,
// control value zero, output word dropped.
module predictive_incremental_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pic_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pic_pkg::CFG_DATA_W-1:0] cfg_wdata,
  pic_in_if.sink                          in_ch,
  pic_out_if.source                       out_ch
);

  pic_pkg::cfg_t  cfg_r;
  pic_pkg::op_t   op;
  pic_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha   <= '0;
      cfg_r.steps   <= pic_pkg::STEPS_W'(1);
      cfg_r.min_out <= pic_pkg::DATA_W'(-pic_pkg::OUT_LIMIT);
      cfg_r.max_out <= pic_pkg::DATA_W'(pic_pkg::OUT_LIMIT);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pic_pkg::REG_ALPHA: cfg_r.alpha   <= cfg_wdata[pic_pkg::ALPHA_W-1:0];
        pic_pkg::REG_STEPS: cfg_r.steps   <= cfg_wdata[pic_pkg::STEPS_W-1:0];
        pic_pkg::REG_MIN:   cfg_r.min_out <= cfg_wdata[pic_pkg::DATA_W-1:0];
        pic_pkg::REG_MAX:   cfg_r.max_out <= cfg_wdata[pic_pkg::DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pic_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  pic_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (op),
    .cfg    (cfg_r),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

>>> src/pic_chk.sv
// Port-level checker for the predictive incremental controller, bound to the top level.
module pic_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [pic_pkg::DATA_W-1:0]  out_control,
  input logic signed [pic_pkg::DELTA_W-1:0] out_step_delta
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_control) && $stable(out_step_delta))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous word in progress");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word appeared while sequencer idle");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && in_ready |=> !out_valid)
    else $error("result word repeated");

endmodule

bind predictive_incremental_controller pic_chk u_pic_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_control    (out_ch.control),
  .out_step_delta (out_ch.step_delta)
);
